// ----- rtl/assert_macros.svh -----
// Assertion macros used by the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset
`define CBA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("cba assertion failed");

// Condition must never be true outside reset
`define CBA_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("cba forbidden condition seen");

`else

`define CBA_ASSERT(lbl, prop)
`define CBA_ASSERT_NEVER(lbl, cond)

`endif

`endif

// ----- rtl/cba_pkg.sv -----
// Shared types and constants of the contiguous bank allocator.
`default_nettype none

package cba_pkg;

  // Default pool size
  localparam int unsigned NUM_BANKS_DEF = 16;

  // Fixed field widths
  localparam int unsigned BANK_W   = 4;
  localparam int unsigned DIM_W    = 8;
  localparam int unsigned LIVE_W   = 5;
  localparam int unsigned STATUS_W = 2;

  // Stream payload widths, padded to whole bytes
  localparam int unsigned S_TDATA_W = 24;
  localparam int unsigned M_TDATA_W = 32;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_BAD_SIZE = 2'd1,
    ST_NO_BANKS = 2'd2,
    ST_UNKNOWN  = 2'd3
  } status_e;

  typedef enum logic {
    FUNC_ALLOC   = 1'b0,
    FUNC_RELEASE = 1'b1
  } func_e;

  // Shape recorded for one allocation, stored under its base bank
  typedef struct packed {
    logic [DIM_W-1:0] rows;
    logic [DIM_W-1:0] cols;
  } handle_t;

endpackage

`default_nettype wire

// ----- rtl/contiguous_bank_allocator.sv -----
// First-fit contiguous bank allocator with busy bitmap and shape table.
//
//  channel   | dir | tdata (low bit up)                              | tuser
//  ----------+-----+-------------------------------------------------+-----------
//  s_axis    | in  | rows[7:0] cols[15:8] release_base[19:16]        | func
//  m_axis    | out | status[1:0] bank[5:2] rows_out[13:6]            | is_alloc
//            |     | cols_out[21:14] handles_live[26:22]             |
//
// Steps: a release reads the shape from the table memory, then multiplies,
// masks and commits. An allocate multiplies, masks, then scans k start
// positions, where k is 1 to NUM_BANKS - rows*cols + 1, and commits; a bad size
// or an oversize run skips the scan. One request is in flight; the next is
// accepted while the result waits in the output register.
// Reset clears bitmap, valid bits and count at once. A stalled output holds commit.
`default_nettype none
`include "assert_macros.svh"

module contiguous_bank_allocator import cba_pkg::*; #(
  parameter int unsigned NUM_BANKS = NUM_BANKS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  // rows, cols, release_base
  input  logic [S_TDATA_W-1:0] s_axis_tdata_i,
  // func
  input  logic                 s_axis_tuser_i,
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  // status, bank, rows_out, cols_out, handles_live
  output logic [M_TDATA_W-1:0] m_axis_tdata_o,
  // is_alloc
  output logic                 m_axis_tuser_o
);

  localparam int unsigned AW     = $clog2(NUM_BANKS);
  localparam int unsigned CW     = $clog2(NUM_BANKS + 1);
  localparam int unsigned NEED_W = 2 * DIM_W;
  localparam int unsigned RBW    = AW + BANK_W;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_READ = 6'b000010,
    S_MUL  = 6'b000100,
    S_MASK = 6'b001000,
    S_SCAN = 6'b010000,
    S_DONE = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // Request fields
  func_e               func_q;
  logic [DIM_W-1:0]    rows_q, cols_q;
  logic [BANK_W-1:0]   rbase_q;

  // Working registers
  logic [NEED_W-1:0]    need_q;
  logic [NUM_BANKS-1:0] win_q;
  logic [AW-1:0]        base_q, limit_q;
  status_e              status_q;

  // Allocator state
  logic [NUM_BANKS-1:0] busy_q, busy_d;
  logic [NUM_BANKS-1:0] hvalid_q, hvalid_d;
  logic [CW-1:0]        live_q, live_d;

  // Output register
  logic              m_valid_q;
  status_e           out_status_q;
  logic [BANK_W-1:0] out_bank_q;
  logic              out_alloc_q;
  logic [DIM_W-1:0]  out_rows_q, out_cols_q;
  logic [LIVE_W-1:0] out_live_q;

  // Datapath helpers
  logic [RBW-1:0]       rb_ext;
  logic [AW-1:0]        rb_idx;
  logic                 rb_in_range;
  logic                 rel_ok;
  handle_t              rd_data;
  handle_t              wr_data;
  logic                 wr_en;
  logic [DIM_W-1:0]     mul_a, mul_b;
  logic [NEED_W-1:0]    product;
  logic [NUM_BANKS-1:0] len_mask;
  logic                 size_zero, need_fits;
  logic [NEED_W-1:0]    limit_full;
  logic                 hit, at_limit;
  logic                 can_out, commit, commit_ok;
  logic [AW+BANK_W-1:0] bank_ext;
  logic [CW+LIVE_W-1:0] live_ext;

  // Input decode
  logic [DIM_W-1:0]  in_rows, in_cols;
  logic [BANK_W-1:0] in_rbase;
  assign in_rows  = s_axis_tdata_i[DIM_W-1:0];
  assign in_cols  = s_axis_tdata_i[2*DIM_W-1:DIM_W];
  assign in_rbase = s_axis_tdata_i[2*DIM_W+BANK_W-1:2*DIM_W];

  assign s_axis_tready_o = (state_q == S_IDLE);

  // Release base as a table index plus range check
  assign rb_ext      = {{AW{1'b0}}, rbase_q};
  assign rb_idx      = rb_ext[AW-1:0];
  assign rb_in_range = rb_ext < RBW'(NUM_BANKS);
  assign rel_ok      = rb_in_range && hvalid_q[rb_idx];

  // Run length: request shape or recorded shape
  assign mul_a   = (func_q == FUNC_RELEASE) ? rd_data.rows : rows_q;
  assign mul_b   = (func_q == FUNC_RELEASE) ? rd_data.cols : cols_q;
  assign product = NEED_W'(mul_a) * NEED_W'(mul_b);

  // Low-aligned window of need_q ones
  always_comb begin
    for (int i = 0; i < NUM_BANKS; i++) begin
      len_mask[i] = NEED_W'(i) < need_q;
    end
  end

  assign size_zero  = (rows_q == '0) || (cols_q == '0);
  assign need_fits  = need_q <= NEED_W'(NUM_BANKS);
  assign limit_full = NEED_W'(NUM_BANKS) - need_q;

  // Scan test at the current start position
  assign hit      = (busy_q & win_q) == '0;
  assign at_limit = base_q == limit_q;

  assign can_out   = !m_valid_q || m_axis_tready_i;
  assign commit    = (state_q == S_DONE) && can_out;
  assign commit_ok = commit && (status_q == ST_OK);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          state_d = (func_e'(s_axis_tuser_i) == FUNC_RELEASE) ? S_READ : S_MUL;
        end
      end
      S_READ: state_d = S_MUL;
      S_MUL:  state_d = S_MASK;
      S_MASK: begin
        if (func_q == FUNC_ALLOC && !size_zero && need_fits) begin
          state_d = S_SCAN;
        end else begin
          state_d = S_DONE;
        end
      end
      S_SCAN: begin
        if (hit || at_limit) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (can_out) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State update on commit
  always_comb begin
    busy_d   = busy_q;
    hvalid_d = hvalid_q;
    live_d   = live_q;
    if (commit_ok) begin
      if (func_q == FUNC_ALLOC) begin
        busy_d         = busy_q | win_q;
        hvalid_d[base_q] = 1'b1;
        if (!hvalid_q[base_q]) begin
          live_d = live_q + CW'(1);
        end
      end else begin
        busy_d           = busy_q & ~win_q;
        hvalid_d[base_q] = 1'b0;
        if (live_q != '0) begin
          live_d = live_q - CW'(1);
        end
      end
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      busy_q    <= '0;
      hvalid_q  <= '0;
      live_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      busy_q   <= busy_d;
      hvalid_q <= hvalid_d;
      live_q   <= live_d;
      if (commit) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          func_q  <= func_e'(s_axis_tuser_i);
          rows_q  <= in_rows;
          cols_q  <= in_cols;
          rbase_q <= in_rbase;
        end
      end
      S_MUL: need_q <= product;
      S_MASK: begin
        limit_q <= limit_full[AW-1:0];
        if (func_q == FUNC_ALLOC) begin
          base_q <= '0;
          win_q  <= len_mask;
          if (size_zero) begin
            status_q <= ST_BAD_SIZE;
          end else if (!need_fits) begin
            status_q <= ST_NO_BANKS;
          end
        end else begin
          base_q   <= rb_idx;
          win_q    <= len_mask << rb_idx;
          status_q <= rel_ok ? ST_OK : ST_UNKNOWN;
        end
      end
      S_SCAN: begin
        if (hit) begin
          status_q <= ST_OK;
        end else if (at_limit) begin
          status_q <= ST_NO_BANKS;
        end else begin
          base_q <= base_q + AW'(1);
          win_q  <= win_q << 1;
        end
      end
      default: ;
    endcase
  end

  // Result fields
  assign bank_ext = {{BANK_W{1'b0}}, base_q};
  assign live_ext = {{LIVE_W{1'b0}}, live_d};

  always_ff @(posedge clk_i) begin
    if (commit) begin
      out_status_q <= status_q;
      out_live_q   <= live_ext[LIVE_W-1:0];
      if (status_q == ST_OK) begin
        out_bank_q  <= bank_ext[BANK_W-1:0];
        out_alloc_q <= (func_q == FUNC_ALLOC);
        out_rows_q  <= (func_q == FUNC_ALLOC) ? rows_q : '0;
        out_cols_q  <= (func_q == FUNC_ALLOC) ? cols_q : '0;
      end else begin
        out_bank_q  <= '0;
        out_alloc_q <= 1'b0;
        out_rows_q  <= '0;
        out_cols_q  <= '0;
      end
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tuser_o  = out_alloc_q;
  assign m_axis_tdata_o  = {5'b0, out_live_q, out_cols_q, out_rows_q, out_bank_q,
                            out_status_q};

  // Shape table: read for release, written on allocate commit
  assign wr_en        = commit_ok && (func_q == FUNC_ALLOC);
  assign wr_data.rows = rows_q;
  assign wr_data.cols = cols_q;

  cba_handle_table #(
    .NUM_BANKS (NUM_BANKS)
  ) u_table (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (base_q),
    .wr_data_i (wr_data),
    .rd_en_i   (state_q == S_READ),
    .rd_addr_i (rb_idx),
    .rd_data_o (rd_data)
  );

  // Checks
  `CBA_ASSERT(a_live_matches_valid, live_q == CW'($countones(hvalid_q)))
  `CBA_ASSERT(a_valid_base_busy, (hvalid_q & ~busy_q) == '0)
  `CBA_ASSERT(a_result_from_commit, $rose(m_valid_q) |-> $past(state_q) == S_DONE)
  `CBA_ASSERT_NEVER(a_scan_past_limit, (state_q == S_SCAN) && (base_q > limit_q))

endmodule

`default_nettype wire

// ----- rtl/cba_handle_table.sv -----
// Per-base shape table: one write port, one registered read port.
`default_nettype none

module cba_handle_table import cba_pkg::*; #(
  parameter int unsigned NUM_BANKS = NUM_BANKS_DEF
) (
  input  logic                         clk_i,
  input  logic                         wr_en_i,
  input  logic [$clog2(NUM_BANKS)-1:0] wr_addr_i,
  input  handle_t                      wr_data_i,
  input  logic                         rd_en_i,
  input  logic [$clog2(NUM_BANKS)-1:0] rd_addr_i,
  output handle_t                      rd_data_o
);

  handle_t mem_q [NUM_BANKS];
  handle_t rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read port, registered
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire
